FILE: hdl/mwpo_pkg.sv
package mwpo_pkg;

    localparam int PHASE_BITS_DEF      = 32;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [63:0] QUARTER_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP  = 2'd0,
        REG_WAVE_SHAPE  = 2'd1,
        REG_WAVE_ENABLE = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        SHAPE_SINE     = 2'd0,
        SHAPE_SQUARE   = 2'd1,
        SHAPE_TRIANGLE = 2'd2,
        SHAPE_SAW      = 2'd3
    } shape_t;

    typedef struct packed {
        shape_t shape;
        logic   enable;
    } cfg_t;

    typedef struct packed {
        logic   valid;
        shape_t shape;
        logic   enable;
        logic   negate;
        logic   square_pos;
        logic   last;
    } stage_ctl_t;

    // quarter-wave sine entry k, taylor series in q30, rounded to full scale
    function automatic logic [63:0] quarter_sine(input logic [63:0] k, input int tb,
                                                 input int sb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] fs;
        logic [63:0] r;
        x    = (k * QUARTER_PI_Q30) >> tb;
        x2   = (x * x) >> 30;
        fs   = (64'd1 << (sb - 1)) - 64'd1;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        r    = (sum * fs + (64'd1 << 29)) >> 30;
        if (r > fs)
        begin
            r = fs;
        end
        return r;
    endfunction

endpackage

FILE: hdl/mwpo_if.sv
interface mwpo_in_if
    import mwpo_pkg::*;
();
    logic valid;
    logic ready;
    logic frame_last;

    modport source (output valid, output frame_last, input ready);
    modport sink (input valid, input frame_last, output ready);
endinterface

interface mwpo_out_if
    import mwpo_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_last;

    modport source (output valid, output sample, output sample_last, input ready);
    modport sink (input valid, input sample, input sample_last, output ready);
endinterface

FILE: hdl/multi_waveform_phase_oscillator_top.sv
// an accepted sample request is registered in the front stage, then in the output register
// throughput: one request per cycle while the sink keeps ready high; the phase
// accumulator update and the registered quarter-wave table read both act on each accept
// reset: all configuration registers and the phase clear to zero, the pipeline
// empties; the sine table is constant and needs no clearing pass
module multi_waveform_phase_oscillator_top
    import mwpo_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    mwpo_in_if.sink               frames,
    mwpo_out_if.source            samples
);
    logic                           accept;
    logic                           back_open;
    cfg_t                           cfg;
    logic [PHASE_BITS-1:0]          phase;
    stage_ctl_t                     ctl;
    logic [SAMPLE_BITS-2:0]         rom_data;
    logic signed [SAMPLE_BITS+32:0] prod;

    mwpo_cfg #(
        .PHASE_BITS (PHASE_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .accept   (accept),
        .cfg      (cfg),
        .phase    (phase)
    );

    mwpo_front #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .frames    (frames),
        .back_open (back_open),
        .phase     (phase),
        .cfg       (cfg),
        .accept    (accept),
        .ctl       (ctl),
        .rom_data  (rom_data),
        .prod      (prod)
    );

    mwpo_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .rom_data (rom_data),
        .prod     (prod),
        .open     (back_open),
        .samples  (samples)
    );

`ifndef SYNTHESIS
    a_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg.enable |-> phase == '0)
        else $error("phase not held at zero while disabled");

    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cfg.enable && !wr_en) |=> phase == $past(phase + u_cfg.step_reg))
        else $error("phase did not advance by the step");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !samples.valid |-> frames.ready)
        else $error("request stalled with an empty output");

    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid |-> samples.sample != {1'b1, {(SAMPLE_BITS - 1){1'b0}}})
        else $error("sample beyond full scale");
`endif
endmodule

FILE: hdl/mwpo_cfg.sv
module mwpo_cfg
    import mwpo_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    input  logic                  accept,
    output cfg_t                  cfg,
    output logic [PHASE_BITS-1:0] phase
);
    localparam int STEP_W = (PHASE_BITS < CFG_DATA_W) ? PHASE_BITS : CFG_DATA_W;

    logic [PHASE_BITS-1:0] step_reg;
    logic [PHASE_BITS-1:0] step_next;
    cfg_t                  cfg_reg;
    cfg_t                  cfg_next;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;

    always_comb
    begin
        step_next  = step_reg;
        cfg_next   = cfg_reg;
        phase_next = phase_reg;
        if (accept)
        begin
            phase_next = cfg_reg.enable ? phase_reg + step_reg : '0;
        end
        if (wr_en)
        begin
            unique case (wr_index)
                REG_PHASE_STEP:
                begin
                    step_next = PHASE_BITS'(wr_data[STEP_W-1:0]);
                end
                REG_WAVE_SHAPE:
                begin
                    cfg_next.shape = shape_t'(wr_data[1:0]);
                end
                REG_WAVE_ENABLE:
                begin
                    cfg_next.enable = wr_data[0];
                    if (!wr_data[0])
                    begin
                        phase_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            cfg_reg   <= '0;
            phase_reg <= '0;
        end
        else
        begin
            step_reg  <= step_next;
            cfg_reg   <= cfg_next;
            phase_reg <= phase_next;
        end
    end

    assign cfg   = cfg_reg;
    assign phase = phase_reg;
endmodule

FILE: hdl/mwpo_front.sv
module mwpo_front
    import mwpo_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mwpo_in_if.sink                          frames,
    input  logic                             back_open,
    input  logic [PHASE_BITS-1:0]            phase,
    input  cfg_t                             cfg,
    output logic                             accept,
    output stage_ctl_t                       ctl,
    output logic [SAMPLE_BITS-2:0]           rom_data,
    output logic signed [SAMPLE_BITS+32:0]   prod
);
    localparam int ROM_N  = 1 << SINE_TABLE_BITS;
    localparam int ADDR_W = SINE_TABLE_BITS + 1;
    localparam int PROD_W = SAMPLE_BITS + 33;

    typedef logic [SAMPLE_BITS-2:0] rom_word_t;
    typedef rom_word_t rom_arr_t [0:ROM_N];

    function automatic rom_arr_t build_rom();
        rom_arr_t t;
        for (int k = 0; k <= ROM_N; k++)
        begin
            t[k] = rom_word_t'(quarter_sine(64'(k), SINE_TABLE_BITS, SAMPLE_BITS));
        end
        return t;
    endfunction

    localparam rom_arr_t SINE_ROM = build_rom();

    logic                         advance;
    logic [31:0]                  p32;
    logic [1:0]                   quad;
    logic [SINE_TABLE_BITS-1:0]   idx;
    logic [ADDR_W-1:0]            rom_addr;
    logic [32:0]                  fold;
    logic [33:0]                  tri_full;
    logic signed [32:0]           mul_op;
    logic signed [SAMPLE_BITS-1:0] fs_s;
    stage_ctl_t                   ctl_reg;
    stage_ctl_t                   ctl_next;
    rom_word_t                    rom_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [PROD_W-1:0]     prod_next;

    generate
        if (PHASE_BITS >= 32)
        begin : g_top_bits
            assign p32 = phase[PHASE_BITS-1 -: 32];
        end
        else
        begin : g_low_pad
            assign p32 = {phase, {(32 - PHASE_BITS){1'b0}}};
        end
    endgenerate

    assign advance = !ctl_reg.valid || back_open;
    assign accept  = advance && frames.valid;
    assign frames.ready = advance;

    assign quad     = p32[31:30];
    assign idx      = p32[29 -: SINE_TABLE_BITS];
    assign rom_addr = quad[0] ? ADDR_W'(ROM_N) - {1'b0, idx} : {1'b0, idx};

    // triangle: fold about half a turn, then 2^31 - 2m
    assign fold     = p32[31] ? 33'h1_0000_0000 - {1'b0, p32} : {1'b0, p32};
    assign tri_full = 34'h0_8000_0000 - {fold, 1'b0};
    assign mul_op   = (cfg.shape == SHAPE_TRIANGLE) ? $signed(tri_full[32:0])
                                                    : $signed({p32[31], p32});
    assign fs_s      = $signed({1'b0, {(SAMPLE_BITS - 1){1'b1}}});
    assign prod_next = PROD_W'(mul_op) * PROD_W'(fs_s);

    always_comb
    begin
        ctl_next            = ctl_reg;
        ctl_next.valid      = accept;
        ctl_next.shape      = cfg.shape;
        ctl_next.enable     = cfg.enable;
        ctl_next.negate     = quad[1];
        ctl_next.square_pos = !phase[PHASE_BITS-1] || (phase[PHASE_BITS-2:0] == '0);
        ctl_next.last       = frames.frame_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_next;
        end
    end

    // table read and ramp product, registered on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rom_reg  <= SINE_ROM[rom_addr];
            prod_reg <= prod_next;
        end
    end

    assign ctl      = ctl_reg;
    assign rom_data = rom_reg;
    assign prod     = prod_reg;
endmodule

FILE: hdl/mwpo_back.sv
module mwpo_back
    import mwpo_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  stage_ctl_t                     ctl,
    input  logic [SAMPLE_BITS-2:0]         rom_data,
    input  logic signed [SAMPLE_BITS+32:0] prod,
    output logic                           open,
    mwpo_out_if.source                     samples
);
    localparam int PROD_W = SAMPLE_BITS + 33;

    logic [PROD_W-1:0]             mag;
    logic [PROD_W-1:0]             mag_rnd;
    logic [SAMPLE_BITS-2:0]        q;
    logic signed [SAMPLE_BITS-1:0] ramp;
    logic signed [SAMPLE_BITS-1:0] sine_v;
    logic signed [SAMPLE_BITS-1:0] fs_v;
    logic signed [SAMPLE_BITS-1:0] v;
    logic                          valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          last_reg;

    // divide by 2^31, half away from zero
    assign mag     = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    assign mag_rnd = mag + (PROD_W'(1) << 30);
    assign q       = mag_rnd[31 +: SAMPLE_BITS-1];
    assign ramp    = prod[PROD_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    assign sine_v  = ctl.negate ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
    assign fs_v    = $signed({1'b0, {(SAMPLE_BITS - 1){1'b1}}});

    always_comb
    begin
        case (ctl.shape) inside
            SHAPE_SINE:               v = sine_v;
            SHAPE_SQUARE:             v = ctl.square_pos ? fs_v : -fs_v;
            SHAPE_TRIANGLE, SHAPE_SAW: v = ramp;
            default:                  v = '0;
        endcase
        if (!ctl.enable)
        begin
            v = '0;
        end
    end

    assign open = !valid_reg || samples.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (open)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (open && ctl.valid)
        begin
            sample_reg <= v;
            last_reg   <= ctl.last;
        end
    end

    assign samples.valid       = valid_reg;
    assign samples.sample      = sample_reg;
    assign samples.sample_last = last_reg;
endmodule

FILE: sim/multi_waveform_phase_oscillator_top_tb.sv
module multi_waveform_phase_oscillator_top_tb;
    import mwpo_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int                   TBL_N    = 1 << SINE_TABLE_BITS_DEF;
    localparam longint               FS       = (64'sd1 <<< (SAMPLE_BITS_DEF - 1)) - 1;
    localparam longint               HALF     = 64'sd2147483648;
    localparam longint               TURN     = 64'sd4294967296;
    localparam int                   LIMIT    = 400000;

    typedef struct packed {
        logic signed [SAMPLE_BITS_DEF-1:0] sample;
        logic                              last;
    } sample_t;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    mwpo_in_if                                   frames ();
    mwpo_out_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) samples ();

    multi_waveform_phase_oscillator_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .frames   (frames),
        .samples  (samples)
    );

    logic        frame_q[$];
    sample_t     due_samples[$];
    int unsigned quarter_wave[0:TBL_N];
    logic [31:0] step_cfg;
    shape_t      shape_cfg;
    logic        enable_cfg;
    logic [31:0] phase_model;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          errors;
    int          cycles;

    function automatic int unsigned sine_entry(int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned r;
        longint unsigned n;
        x    = (64'(k) * QUARTER_PI_Q30) >> SINE_TABLE_BITS_DEF;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (n = 3; n <= 13; n += 2)
        begin
            term = ((term * x2) >> 30) / ((n - 1) * n);
            if (((n - 3) / 2) % 2 == 0)
            begin
                acc = acc - term;
            end
            else
            begin
                acc = acc + term;
            end
        end
        r = (acc * 64'(FS) + (64'd1 << 29)) >> 30;
        if (r > 64'(FS))
        begin
            r = 64'(FS);
        end
        return int'(r);
    endfunction

    function automatic longint round_q31(longint num);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (mag + (64'sd1 <<< 30)) >>> 31;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint wave_at(logic [31:0] p);
        longint m;
        longint sp;
        longint v;
        int     idx;
        case (shape_cfg)
            SHAPE_SQUARE:
            begin
                v = (p <= 32'h8000_0000) ? FS : -FS;
            end
            SHAPE_TRIANGLE:
            begin
                m = (longint'(p) < HALF) ? longint'(p) : TURN - longint'(p);
                v = round_q31(FS * (HALF - 2 * m));
            end
            SHAPE_SAW:
            begin
                sp = $signed(p);
                v  = round_q31(FS * sp);
            end
            default:
            begin
                idx = int'(p[29 -: SINE_TABLE_BITS_DEF]);
                v   = quarter_wave[p[30] ? TBL_N - idx : idx];
                if (p[31])
                begin
                    v = -v;
                end
            end
        endcase
        if (v > FS)
        begin
            v = FS;
        end
        if (v < -FS)
        begin
            v = -FS;
        end
        return v;
    endfunction

    function automatic sample_t next_sample(logic last);
        sample_t s;
        s.last   = last;
        s.sample = '0;
        if (enable_cfg)
        begin
            s.sample    = SAMPLE_BITS_DEF'(wave_at(phase_model));
            phase_model = phase_model + step_cfg;
        end
        else
        begin
            phase_model = '0;
        end
        return s;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_PHASE_STEP:
            begin
                step_cfg = data;
            end
            REG_WAVE_SHAPE:
            begin
                shape_cfg = shape_t'(data[1:0]);
            end
            REG_WAVE_ENABLE:
            begin
                enable_cfg = data[0];
                if (!data[0])
                begin
                    phase_model = '0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic wait_idle();
        while (frame_q.size() != 0 || frames.valid || due_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic restart_phase();
        write_reg(REG_WAVE_ENABLE, 32'd0);
        write_reg(REG_WAVE_ENABLE, 32'd1);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        for (int k = 0; k <= TBL_N; k++)
        begin
            quarter_wave[k] = sine_entry(k);
        end
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames.valid      <= 1'b0;
            frames.frame_last <= 1'b0;
        end
        else
        begin
            if (frames.valid && frames.ready)
            begin
                due_samples.push_back(next_sample(frames.frame_last));
            end
            if (!frames.valid || frames.ready)
            begin
                if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    frames.valid      <= 1'b1;
                    frames.frame_last <= frame_q.pop_front();
                end
                else
                begin
                    frames.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : monitor
        sample_t want;
        if (!rst_n)
        begin
            samples.ready <= 1'b0;
        end
        else
        begin
            if (samples.valid && samples.ready)
            begin
                if (due_samples.size() == 0)
                begin
                    $error("unexpected sample %0d last %0b", samples.sample,
                           samples.sample_last);
                    errors++;
                end
                else
                begin
                    want = due_samples.pop_front();
                    if (samples.sample !== want.sample)
                    begin
                        $error("sample mismatch: expected %0d, got %0d", want.sample,
                               samples.sample);
                        errors++;
                    end
                    if (samples.sample_last !== want.last)
                    begin
                        $error("sample_last mismatch: expected %0b, got %0b", want.last,
                               samples.sample_last);
                        errors++;
                    end
                end
            end
            samples.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] step;
        logic        en;
        shape_t      shp;
        rst_n          = 1'b0;
        wr_en          = 1'b0;
        wr_index       = REG_PHASE_STEP;
        wr_data        = '0;
        step_cfg       = '0;
        shape_cfg      = SHAPE_SINE;
        enable_cfg     = 1'b0;
        phase_model    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        errors         = 0;
        cycles         = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // disabled after reset: silence, last still copied
        frame_q.push_back(1'b1);
        frame_q.push_back(1'b0);
        frame_q.push_back(1'b1);
        wait_idle();

        // quarter-turn steps through every shape
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        for (int s = 0; s < 4; s++)
        begin
            write_reg(REG_WAVE_SHAPE, 32'(shape_t'(s)));
            restart_phase();
            for (int k = 0; k < 4; k++)
            begin
                frame_q.push_back(k[0]);
            end
            wait_idle();
        end

        // largest step moves the phase back by one per sample
        write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        frame_q.push_back(1'b0);
        frame_q.push_back(1'b1);
        wait_idle();

        // unused index must change nothing; square just past half a turn
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        write_reg(REG_WAVE_SHAPE, 32'(SHAPE_SQUARE));
        write_reg(REG_PHASE_STEP, 32'h8000_0001);
        restart_phase();
        frame_q.push_back(1'b1);
        frame_q.push_back(1'b0);
        wait_idle();

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 86;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 86;
                end
                default:
                begin
                    send_idle_pct  = 35;
                    recv_stall_pct = 35;
                end
            endcase
            case ($urandom_range(5))
                0: step = 32'd0;
                1: step = 32'hFFFF_FFFF;
                2: step = 32'h8000_0000;
                3: step = $urandom_range(1 << 16);
                default: step = $urandom;
            endcase
            if (ph == 0)
            begin
                step = 32'd0;
            end
            shp = shape_t'($urandom_range(3));
            en  = ($urandom_range(99) < 85);
            write_reg(REG_PHASE_STEP, step);
            write_reg(REG_WAVE_SHAPE, ($urandom & ~32'h3) | 32'(shp));
            if ($urandom_range(3) == 0)
            begin
                write_reg(REG_NONE, $urandom);
            end
            if ($urandom_range(1) == 0)
            begin
                write_reg(REG_WAVE_ENABLE, $urandom & ~32'h1);
            end
            write_reg(REG_WAVE_ENABLE, ($urandom & ~32'h1) | 32'(en));
            for (int k = 0; k < 75; k++)
            begin
                frame_q.push_back(1'($urandom_range(1)));
            end
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: multi_waveform_phase_oscillator_top.f
hdl/mwpo_pkg.sv
hdl/mwpo_if.sv
hdl/mwpo_cfg.sv
hdl/mwpo_front.sv
hdl/mwpo_back.sv
hdl/multi_waveform_phase_oscillator_top.sv
sim/multi_waveform_phase_oscillator_top_tb.sv
